### hw/rtl/ws2812_led_strip_driver_top_assert.svh
// Assertion macros shared by the LED strip driver RTL.
// No dependencies; the including module provides i_clk and i_rst_n.
`ifndef WS2812_LED_STRIP_DRIVER_TOP_ASSERT_SVH
`define WS2812_LED_STRIP_DRIVER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define WS2812_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
// consequence that must hold in the cycle after the antecedent
`define WS2812_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WS2812_ASSERT(lbl, prop, msg)
`define WS2812_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hw/rtl/ws2812_pkg.sv
// Shared types, codes and constants of the LED strip driver.
// No dependencies; imported by every RTL module of the block.
`default_nettype none

package ws2812_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH      = 3'd4;

    // field widths
    localparam int LED_CNT_W = 9;
    localparam int TICK_W    = 16;
    localparam int BITPOS_W  = 5;
    localparam int COLOR_W   = 24;

    // register reset values
    localparam logic [LED_CNT_W-1:0] RST_LED_COUNT  = 9'd0;
    localparam logic [7:0]           RST_ZERO_HIGH  = 8'd20;
    localparam logic [7:0]           RST_ONE_HIGH   = 8'd40;
    localparam logic [7:0]           RST_BIT_PERIOD = 8'd63;
    localparam logic [TICK_W-1:0]    RST_LATCH      = 16'd2500;

    localparam int MAX_LEDS_DEF = 256;
    localparam logic [BITPOS_W-1:0] BITS_PER_PIXEL = 5'd24;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_SHOW  = 2'd2,
        REQ_TICK  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_BUSY  = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] pixel_index;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in_item;

    typedef struct packed {
        logic       line_level;
        logic [1:0] status;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       busy_res;
    } t_out_item;

    // classified request, color packed green/red/blue from high to low
    typedef struct packed {
        t_req                kind;
        logic [7:0]          index;
        logic [COLOR_W-1:0]  color;
        logic                oor;
    } t_op;

    typedef struct packed {
        logic [7:0]           zero_high;
        logic [7:0]           one_high;
        logic [7:0]           period;
        logic [TICK_W-1:0]    latch;
        logic [LED_CNT_W-1:0] eff_count;
    } t_cfg;

endpackage

`default_nettype wire

### hw/rtl/ws2812_queue.sv
// Two-entry queue of classified requests between front and engine.
// Depends on ws2812_pkg and the assertion macro header.
`default_nettype none

module ws2812_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  ws2812_pkg::t_op     i_op,
    output logic                o_full,
    output logic                o_valid,
    input  wire logic           i_pop,
    output ws2812_pkg::t_op     o_head
);
    import ws2812_pkg::*;

`include "ws2812_led_strip_driver_top_assert.svh"

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_op               r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_slot[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `WS2812_ASSERT(a_q_no_overflow, !(i_push && o_full), "push into full queue")
    `WS2812_ASSERT(a_q_no_underflow, !(i_pop && !o_valid), "pop from empty queue")
    `WS2812_ASSERT(a_q_count_range, r_count <= CNT_W'(QUEUE_DEPTH), "queue count out of range")
    `WS2812_ASSERT_NEXT(a_q_fill, i_push && !i_pop, o_valid, "pushed entry not visible")

endmodule

`default_nettype wire

### hw/rtl/ws2812_front.sv
// Request front end: accepts input beats and classifies them for the engine.
// Depends on ws2812_pkg.
`default_nettype none

module ws2812_front (
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  ws2812_pkg::t_in_item                i_in_item,
    input  wire logic [ws2812_pkg::LED_CNT_W-1:0] i_eff_count,
    input  wire logic                           i_q_full,
    output logic                                o_push,
    output ws2812_pkg::t_op                     o_op
);
    import ws2812_pkg::*;

    // accept whenever the queue has room
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // decode request and check the index against the strip length
    always_comb begin
        o_op.kind  = t_req'(i_in_item.req_type);
        o_op.index = i_in_item.pixel_index;
        o_op.color = {i_in_item.green_in, i_in_item.red_in, i_in_item.blue_in};
        o_op.oor   = ({1'b0, i_in_item.pixel_index} >= i_eff_count);
    end

endmodule

`default_nettype wire

### hw/rtl/ws2812_engine.sv
// Back end: pixel store, line waveform sequencer and result register.
// Depends on ws2812_pkg and the assertion macro header.
`default_nettype none

module ws2812_engine #(
    parameter int MAX_LEDS = ws2812_pkg::MAX_LEDS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  ws2812_pkg::t_cfg     i_cfg,
    input  wire logic            i_q_valid,
    input  ws2812_pkg::t_op      i_head,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output ws2812_pkg::t_out_item o_out_item
);
    import ws2812_pkg::*;

`include "ws2812_led_strip_driver_top_assert.svh"

    // only indexes below 256 can ever be written
    localparam int SD = (MAX_LEDS < 256) ? MAX_LEDS : 256;
    localparam int AW = (SD > 1) ? $clog2(SD) : 1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FRAME,
        PH_LATCH
    } t_phase;

    t_phase                r_phase,  n_phase;
    logic [TICK_W-1:0]     r_tc,     n_tc;
    logic [BITPOS_W-1:0]   r_bp,     n_bp;
    logic [LED_CNT_W-1:0]  r_pp,     n_pp;
    logic [COLOR_W-1:0]    r_shift,  n_shift;
    logic                  r_line,   n_line;
    logic                  r_o_valid;
    t_status               r_status, n_status;
    logic                  r_is_read, n_is_read;

    // store
    logic [COLOR_W-1:0]    r_mem [SD];
    logic [SD-1:0]         r_vld;
    logic [COLOR_W-1:0]    r_pix0;
    logic [COLOR_W-1:0]    r_rdata;

    logic                  fire;
    logic                  wr_en;
    logic                  rd_en;
    logic [LED_CNT_W-1:0]  rd_pos;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic                  rd_hit;
    logic [7:0]            high;
    logic [TICK_W-1:0]     tc1;
    logic [BITPOS_W-1:0]   bp1;
    logic [LED_CNT_W-1:0]  pp1;

    // execute when a request waits and the result register is free
    assign fire  = i_q_valid && (!r_o_valid || !i_out_stall);
    assign o_pop = fire;

    assign wr_addr = i_head.index[AW-1:0];
    assign rd_addr = rd_pos[AW-1:0];
    assign rd_hit  = (rd_pos < LED_CNT_W'(SD)) && r_vld[rd_addr];

    // next state of the sequencer for the request at the queue head
    always_comb begin
        n_phase   = r_phase;
        n_tc      = r_tc;
        n_bp      = r_bp;
        n_pp      = r_pp;
        n_shift   = r_shift;
        n_line    = r_line;
        n_status  = ST_OK;
        n_is_read = 1'b0;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        rd_pos    = {1'b0, i_head.index};
        high      = r_shift[COLOR_W-1] ? i_cfg.one_high : i_cfg.zero_high;
        tc1       = r_tc + 16'd1;
        bp1       = r_bp + 5'd1;
        pp1       = r_pp + 9'd1;

        if (i_head.kind == REQ_TICK) begin
            unique case (r_phase)
                PH_FRAME: begin
                    n_line = (r_tc < TICK_W'(high));
                    if (tc1 >= TICK_W'(i_cfg.period)) begin
                        n_tc    = '0;
                        n_shift = {r_shift[COLOR_W-2:0], 1'b0};
                        if (bp1 >= BITS_PER_PIXEL) begin
                            n_bp = '0;
                            n_pp = pp1;
                            if (pp1 >= i_cfg.eff_count) begin
                                // last pixel done: go latch, or idle with no latch time
                                n_phase = (i_cfg.latch != '0) ? PH_LATCH : PH_IDLE;
                            end else begin
                                // take the prefetched pixel, prefetch the one after
                                n_shift = r_rdata;
                                rd_en   = 1'b1;
                                rd_pos  = pp1 + 9'd1;
                            end
                        end else begin
                            n_bp = bp1;
                        end
                    end else begin
                        n_tc = tc1;
                    end
                end
                PH_LATCH: begin
                    n_line = 1'b0;
                    if (tc1 >= i_cfg.latch) begin
                        n_tc    = '0;
                        n_phase = PH_IDLE;
                    end else begin
                        n_tc = tc1;
                    end
                end
                default: begin
                    n_line = 1'b0;
                end
            endcase
        end else if (r_phase != PH_IDLE) begin
            n_status = ST_BUSY;
        end else begin
            unique case (i_head.kind)
                REQ_SHOW: begin
                    n_pp   = '0;
                    n_bp   = '0;
                    n_tc   = '0;
                    n_line = 1'b0;
                    if (i_cfg.eff_count != '0) begin
                        n_phase = PH_FRAME;
                        n_shift = r_pix0;
                        rd_en   = 1'b1;
                        rd_pos  = 9'd1;
                    end else begin
                        n_phase = (i_cfg.latch != '0) ? PH_LATCH : PH_IDLE;
                    end
                end
                REQ_WRITE: begin
                    if (i_head.oor) begin
                        n_status = ST_RANGE;
                    end else begin
                        wr_en = 1'b1;
                    end
                end
                REQ_READ: begin
                    if (i_head.oor) begin
                        n_status = ST_RANGE;
                    end else begin
                        rd_en     = 1'b1;
                        n_is_read = 1'b1;
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    // sequencer state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_tc      <= '0;
            r_bp      <= '0;
            r_pp      <= '0;
            r_shift   <= '0;
            r_line    <= 1'b0;
            r_o_valid <= 1'b0;
            r_status  <= ST_OK;
            r_is_read <= 1'b0;
        end else begin
            if (fire) begin
                r_phase   <= n_phase;
                r_tc      <= n_tc;
                r_bp      <= n_bp;
                r_pp      <= n_pp;
                r_shift   <= n_shift;
                r_line    <= n_line;
                r_status  <= n_status;
                r_is_read <= n_is_read;
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // pixel memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (fire && wr_en) begin
            r_mem[wr_addr] <= i_head.color;
        end
        if (fire && rd_en) begin
            r_rdata <= rd_hit ? r_mem[rd_addr] : '0;
        end
    end

    // valid bits and pixel zero copy, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_pix0 <= '0;
        end else if (fire && wr_en) begin
            r_vld[wr_addr] <= 1'b1;
            if (i_head.index == '0) begin
                r_pix0 <= i_head.color;
            end
        end
    end

    // result beat
    always_comb begin
        o_out_valid           = r_o_valid;
        o_out_item.line_level = r_line;
        o_out_item.status     = r_status;
        o_out_item.green_out  = r_is_read ? r_rdata[23:16] : 8'd0;
        o_out_item.red_out    = r_is_read ? r_rdata[15:8]  : 8'd0;
        o_out_item.blue_out   = r_is_read ? r_rdata[7:0]   : 8'd0;
        o_out_item.busy_res   = (r_phase != PH_IDLE);
    end

    `WS2812_ASSERT(a_bp_range, r_bp < BITS_PER_PIXEL, "bit position out of range")
    `WS2812_ASSERT(a_frame_tc, r_phase != PH_FRAME || r_tc[15:8] == '0, "slot tick count too big")
    `WS2812_ASSERT(a_write_idle, !(fire && wr_en) || r_phase == PH_IDLE, "store write while busy")
    `WS2812_ASSERT(a_hold_result, !(r_o_valid && i_out_stall && fire), "result overwritten")
    `WS2812_ASSERT_NEXT(a_busy_noread, fire && r_phase != PH_IDLE && i_head.kind == REQ_READ, !r_is_read, "busy read returned data")

endmodule

`default_nettype wire

### hw/rtl/ws2812_led_strip_driver_top.sv
// Top level of the single-wire LED strip driver: configuration registers
// and the front, queue and engine. Depends on ws2812_pkg and the submodules.
//
// Usage:
//   Input beats (i_in_valid / o_in_stall) carry one request: write pixel,
//   read pixel, start show, or tick. Every request yields exactly one
//   result beat (o_out_valid / i_out_stall) with the line level, a status,
//   read color and the busy flag. Tick requests step the line waveform by
//   one tick, so the line timing follows the tick beat rate.
//   One request per cycle is sustained when the output is not stalled, set
//   by the single execute step of the engine and its single memory port
//   (pixel data for a frame is prefetched). A stalled result holds in the
//   output register; the two-entry request queue then fills and o_in_stall
//   rises until the result is taken. Configuration writes (i_cfg_valid,
//   always ready) must be made while idle; the block does not check this.
//   Reset (synchronous, active low) restores register defaults, idles the
//   line low and marks all pixels black through per-entry valid bits;
//   there is no clearing sweep, so requests are taken right after reset.
`default_nettype none

module ws2812_led_strip_driver_top #(
    parameter int MAX_LEDS = ws2812_pkg::MAX_LEDS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  ws2812_pkg::t_in_item                   i_in_item,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output ws2812_pkg::t_out_item                  o_out_item,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [ws2812_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ws2812_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ws2812_pkg::*;

    // a 9-bit count can never exceed a larger strip limit
    localparam int EFF_CAP = (MAX_LEDS > (2 ** LED_CNT_W - 1)) ? (2 ** LED_CNT_W - 1) : MAX_LEDS;

    logic [LED_CNT_W-1:0] r_led_count;
    logic [7:0]           r_zero_high;
    logic [7:0]           r_one_high;
    logic [7:0]           r_period;
    logic [TICK_W-1:0]    r_latch;
    t_cfg                 cfg;
    logic                 q_push;
    logic                 q_full;
    logic                 q_valid;
    logic                 q_pop;
    t_op                  q_in;
    t_op                  q_head;

    assign o_cfg_ready = 1'b1;

    // configuration register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_count <= RST_LED_COUNT;
            r_zero_high <= RST_ZERO_HIGH;
            r_one_high  <= RST_ONE_HIGH;
            r_period    <= RST_BIT_PERIOD;
            r_latch     <= RST_LATCH;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LED_COUNT:  r_led_count <= i_cfg_data[LED_CNT_W-1:0];
                CFG_ZERO_HIGH:  r_zero_high <= i_cfg_data[7:0];
                CFG_ONE_HIGH:   r_one_high  <= i_cfg_data[7:0];
                CFG_BIT_PERIOD: r_period    <= i_cfg_data[7:0];
                CFG_LATCH:      r_latch     <= i_cfg_data[TICK_W-1:0];
                default:        r_latch     <= r_latch;
            endcase
        end
    end

    // settings seen by the front and engine, count clamped to the strip limit
    always_comb begin
        cfg.zero_high = r_zero_high;
        cfg.one_high  = r_one_high;
        cfg.period    = r_period;
        cfg.latch     = r_latch;
        cfg.eff_count = (r_led_count > LED_CNT_W'(EFF_CAP)) ? LED_CNT_W'(EFF_CAP)
                                                            : r_led_count;
    end

    ws2812_front u_front (
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_eff_count (cfg.eff_count),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_op        (q_in)
    );

    ws2812_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_head  (q_head)
    );

    ws2812_engine #(
        .MAX_LEDS (MAX_LEDS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire
